// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property held at every clock edge outside reset
`define DPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dps assertion failed");

// Overlapping implication held outside reset
`define DPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dps implication failed");

// Implication whose consequent is checked at the next clock edge, held outside reset
`define DPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dps next-cycle implication failed");

`endif

// ===== hdl/dps_pkg.sv =====
// Types and constants of the dilution program sequencer.
package dps_pkg;

   // Step opcodes; codes 6 and 7 are stored as given and never complete
   typedef enum logic [2:0] {
      OP_END     = 3'd0,
      OP_MONITOR = 3'd1,
      OP_OUTFLOW = 3'd2,
      OP_INFLOW  = 3'd3,
      OP_WAIT    = 3'd4,
      OP_PAUSE   = 3'd5
   } opcode_type;

   // Item kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Control register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_ENABLED     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY_SETPOINT = 1'd1;

   localparam logic [15:0] SETPOINT_RESET = 16'd200;

   // Input item
   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic [15:0] density_sample;
      logic [2:0]  load_index;
      logic [2:0]  load_opcode;
      logic [30:0] load_value;
   } req_type;

   // Result item
   typedef struct packed {
      logic               inflow_on;
      logic               outflow_on;
      logic [2:0]         current_step;
      logic signed [31:0] countdown_ms;
      logic               step_finished;
      logic               is_paused;
   } rsp_type;

   // One program table entry as held in memory
   typedef struct packed {
      logic [2:0]  op;
      logic [30:0] value;
   } entry_type;

endpackage

// ===== hdl/dps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module dps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write port and read-before-write read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== hdl/dilution_protocol_sequencer_unit.sv =====
// Top level of the dilution program sequencer: table memories, step evaluation, result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (tick or program load)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (state after the item)
//   csr      in         csr_write_enable       csr_index, csr_wdata
//
// One item per cycle while no result is stalled: an item is evaluated in the cycle of
// its transfer and its result appears in the output register on the next cycle. The
// step pointer loop (evaluate, advance, re-address both table memories) closes through
// the pointer register and the registered memory reads. Reset clears control state and
// the entry valid bits; no clearing pass. While a result is stalled no item is taken until it drains.
module dilution_protocol_sequencer_unit import dps_pkg::*; #(
   parameter int PROGRAM_DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW = $clog2(PROGRAM_DEPTH);
   localparam int EW = $bits(entry_type);
   localparam logic [PW-1:0] LAST_IDX = PW'(PROGRAM_DEPTH - 1);

   // Control registers
   logic        loop_en_ff,  loop_en_in;
   logic [15:0] setpoint_ff, setpoint_in;

   // Sequencer state
   logic [PW-1:0] ptr_ff,        ptr_in;
   logic          wait_active_ff, wait_active_in;
   logic [31:0]   wait_start_ff, wait_start_in;
   logic [31:0]   remaining_ff,  remaining_in;
   logic          pause_ff,      pause_in;
   logic          inflow_ff,     inflow_in;
   logic          outflow_ff,    outflow_in;
   logic [2:0]    op0_ff,        op0_in;

   // Table bookkeeping: valid bits, read valids and write bypass
   logic [PROGRAM_DEPTH-1:0] valid_ff, valid_in;
   logic          rd_valid_a_ff, rd_valid_a_in;
   logic          rd_valid_b_ff, rd_valid_b_in;
   logic          byp_a_ff,      byp_a_in;
   logic          byp_b_ff,      byp_b_in;
   entry_type     byp_data_ff;

   // Result register
   logic          rsp_valid_ff,  rsp_valid_in;
   rsp_type       rsp_data_ff,   rsp_data_in;

   logic          accept;
   logic          tick_run;
   logic          done;
   logic          wrap;
   logic          we;
   logic [PW-1:0] waddr;
   entry_type     wdata;
   logic [PW-1:0] raddr_a, raddr_b;
   logic [EW-1:0] ram_a_rdata, ram_b_rdata;
   entry_type     cur, nxt;
   logic [2:0]    new_op;
   logic [31:0]   wait_diff;

   // Handshake: the result register frees when taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign tick_run  = accept & (req_data.func == FUNC_TICK) & loop_en_ff & ~pause_ff;

   // Table write for a load within the table
   assign we    = accept & (req_data.func == FUNC_LOAD)
                  & (32'(req_data.load_index) < 32'(PROGRAM_DEPTH));
   assign waddr = PW'(req_data.load_index);
   assign wdata = '{op: req_data.load_opcode, value: req_data.load_value};

   // Entries at the pointer and after it, with bypass and reset value
   always_comb begin
      if (byp_a_ff) begin
         cur = byp_data_ff;
      end else if (rd_valid_a_ff) begin
         cur = entry_type'(ram_a_rdata);
      end else begin
         cur = '0;
      end
      if (byp_b_ff) begin
         nxt = byp_data_ff;
      end else if (rd_valid_b_ff) begin
         nxt = entry_type'(ram_b_rdata);
      end else begin
         nxt = '0;
      end
   end

   // Step evaluation
   always_comb begin
      wait_active_in = wait_active_ff;
      wait_start_in  = wait_start_ff;
      remaining_in   = remaining_ff;
      pause_in       = pause_ff;
      inflow_in      = inflow_ff;
      outflow_in     = outflow_ff;
      done           = 1'b0;
      wait_diff      = 32'({1'b0, cur.value}) - (req_data.now_ms - wait_start_ff);
      if (tick_run) begin
         case (cur.op)
            OP_MONITOR: begin
               done = (cur.value == '0) | (req_data.density_sample < setpoint_ff);
            end
            OP_OUTFLOW: begin
               outflow_in = (cur.value != '0);
               done       = 1'b1;
            end
            OP_INFLOW: begin
               inflow_in = (cur.value != '0);
               done      = 1'b1;
            end
            OP_WAIT: begin
               if (!wait_active_ff) begin
                  wait_active_in = 1'b1;
                  wait_start_in  = req_data.now_ms;
                  remaining_in   = 32'({1'b0, cur.value});
               end else if (wait_diff[31]) begin
                  done           = 1'b1;
                  wait_active_in = 1'b0;
                  remaining_in   = '0;
               end else begin
                  remaining_in = wait_diff;
               end
            end
            OP_PAUSE: begin
               pause_in = (cur.value == '0);
            end
            default: begin
               done = 1'b0;
            end
         endcase
      end
   end

   // Pointer advance and memory read addresses
   always_comb begin
      wrap   = (ptr_ff == LAST_IDX) | (nxt.op == OP_END);
      ptr_in = ptr_ff;
      new_op = cur.op;
      if (done) begin
         if (wrap) begin
            ptr_in = '0;
            new_op = op0_ff;
         end else begin
            ptr_in = ptr_ff + 1'b1;
            new_op = nxt.op;
         end
      end else if (we && (waddr == ptr_ff)) begin
         new_op = wdata.op;
      end
      raddr_a = ptr_in;
      raddr_b = (ptr_in == LAST_IDX) ? '0 : ptr_in + 1'b1;
   end

   // Valid bits, read valids, bypass and entry-0 opcode copy
   always_comb begin
      valid_in = valid_ff;
      op0_in   = op0_ff;
      if (we) begin
         valid_in = valid_ff | ({{(PROGRAM_DEPTH-1){1'b0}}, 1'b1} << waddr);
         if (waddr == '0) begin
            op0_in = wdata.op;
         end
      end
      rd_valid_a_in = valid_ff[raddr_a];
      rd_valid_b_in = valid_ff[raddr_b];
      byp_a_in      = we & (waddr == raddr_a);
      byp_b_in      = we & (waddr == raddr_b);
   end

   // Control register writes
   always_comb begin
      loop_en_in  = loop_en_ff;
      setpoint_in = setpoint_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LOOP_ENABLED:     loop_en_in  = csr_wdata[0];
            CSR_DENSITY_SETPOINT: setpoint_in = csr_wdata;
            default:              loop_en_in  = loop_en_ff;
         endcase
      end
   end

   // Result of the item in transfer
   always_comb begin
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_data_in.inflow_on     = inflow_in;
         rsp_data_in.outflow_on    = outflow_in;
         rsp_data_in.current_step  = 3'(ptr_in);
         rsp_data_in.countdown_ms  = (new_op == OP_WAIT) ? signed'(remaining_in) : '0;
         rsp_data_in.step_finished = done;
         rsp_data_in.is_paused     = pause_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_en_ff     <= 1'b0;
         setpoint_ff    <= SETPOINT_RESET;
         ptr_ff         <= '0;
         wait_active_ff <= 1'b0;
         wait_start_ff  <= '0;
         remaining_ff   <= '0;
         pause_ff       <= 1'b0;
         inflow_ff      <= 1'b0;
         outflow_ff     <= 1'b0;
         op0_ff         <= OP_END;
         valid_ff       <= '0;
         rd_valid_a_ff  <= 1'b0;
         rd_valid_b_ff  <= 1'b0;
         byp_a_ff       <= 1'b0;
         byp_b_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         loop_en_ff     <= loop_en_in;
         setpoint_ff    <= setpoint_in;
         ptr_ff         <= ptr_in;
         wait_active_ff <= wait_active_in;
         wait_start_ff  <= wait_start_in;
         remaining_ff   <= remaining_in;
         pause_ff       <= pause_in;
         inflow_ff      <= inflow_in;
         outflow_ff     <= outflow_in;
         op0_ff         <= op0_in;
         valid_ff       <= valid_in;
         rd_valid_a_ff  <= rd_valid_a_in;
         rd_valid_b_ff  <= rd_valid_b_in;
         byp_a_ff       <= byp_a_in;
         byp_b_ff       <= byp_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byp_data_ff <= wdata;
      rsp_data_ff <= rsp_data_in;
   end

   // Two copies of the table: one read at the pointer, one after it
   dps_ram #(
      .WIDTH (EW),
      .DEPTH (PROGRAM_DEPTH)
   ) u_ram_cur (
      .clock      (clock),
      .write_en   (we),
      .write_addr (waddr),
      .write_data (wdata),
      .read_addr  (raddr_a),
      .read_data  (ram_a_rdata)
   );

   dps_ram #(
      .WIDTH (EW),
      .DEPTH (PROGRAM_DEPTH)
   ) u_ram_nxt (
      .clock      (clock),
      .write_en   (we),
      .write_addr (waddr),
      .write_data (wdata),
      .read_addr  (raddr_b),
      .read_data  (ram_b_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/dps_checker.sv =====
// Port-level assertions for the sequencer top level, with its bind.
`include "assert_macros.svh"

module dps_checker import dps_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic       rsp_xfer;
   logic       paused_seen_ff, paused_seen_in;
   logic       have_last_ff,   have_last_in;
   logic [2:0] last_step_ff,   last_step_in;

   assign rsp_xfer = rsp_valid & ~rsp_stall;

   // History of transferred results
   always_comb begin
      paused_seen_in = paused_seen_ff | (rsp_xfer & rsp_data.is_paused);
      have_last_in   = have_last_ff | rsp_xfer;
      last_step_in   = rsp_xfer ? rsp_data.current_step : last_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_seen_ff <= 1'b0;
         have_last_ff   <= 1'b0;
         last_step_ff   <= '0;
      end else begin
         paused_seen_ff <= paused_seen_in;
         have_last_ff   <= have_last_in;
         last_step_ff   <= last_step_in;
      end
   end

   // A stalled result stays offered and unchanged
   `DPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `DPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // Pause is final until reset
   `DPS_ASSERT_IMP(a_pause_final, clock, reset, rsp_valid && paused_seen_ff, rsp_data.is_paused)

   // The step index moves only with a finished step
   `DPS_ASSERT_IMP(a_step_moves, clock, reset, rsp_valid && have_last_ff && !rsp_data.step_finished, rsp_data.current_step == last_step_ff)

endmodule

bind dilution_protocol_sequencer_unit dps_checker u_dps_checker (.*);

// ===== bench/dps_result_checker.sv =====
// Checker for the dilution program sequencer: predicts each result and compares transfers.
`timescale 1ns / 100ps

module dps_result_checker #(
   parameter int PROGRAM_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  dps_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  dps_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [dps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              results_pending
);
   import dps_pkg::*;

   // Shadow copy of the sequencer state and its control registers
   logic [2:0]  prog_op  [PROGRAM_DEPTH];
   logic [30:0] prog_val [PROGRAM_DEPTH];
   logic [2:0]  step_ptr;
   logic        wait_on;
   logic [31:0] wait_base;
   logic [31:0] wait_left;
   logic        paused;
   logic        inflow_q;
   logic        outflow_q;
   logic        loop_en;
   logic [15:0] setpoint;

   // States predicted for results not yet transferred, oldest first
   rsp_type predicted_states[$];
   rsp_type got_state;
   rsp_type want_state;
   rsp_type next_state;

   task note_failure(input string msg);
      begin
         $display("mismatch at %0t: %s", $realtime, msg);
         error_count++;
      end
   endtask

   task reset_sequencer();
      int i;
      begin
         for (i = 0; i < PROGRAM_DEPTH; i++) begin
            prog_op[i]  = OP_END;
            prog_val[i] = '0;
         end
         step_ptr  = '0;
         wait_on   = 1'b0;
         wait_base = '0;
         wait_left = '0;
         paused    = 1'b0;
         inflow_q  = 1'b0;
         outflow_q = 1'b0;
         loop_en   = 1'b0;
         setpoint  = SETPOINT_RESET;
      end
   endtask

   // Apply one item to the shadow state and form the state it leaves behind
   task advance_sequencer(input req_type r, output rsp_type e);
      logic        done;
      logic [3:0]  nxt;
      logic [2:0]  op;
      logic [30:0] val;
      begin
         done = 1'b0;
         if (r.func == FUNC_LOAD) begin
            if (int'(r.load_index) < PROGRAM_DEPTH) begin
               prog_op[r.load_index]  = r.load_opcode;
               prog_val[r.load_index] = r.load_value;
            end
         end else if (loop_en && !paused) begin
            op  = prog_op[step_ptr];
            val = prog_val[step_ptr];
            case (op)
               OP_MONITOR: done = (val == '0) || (r.density_sample < setpoint);
               OP_OUTFLOW: begin
                  outflow_q = (val != '0);
                  done = 1'b1;
               end
               OP_INFLOW: begin
                  inflow_q = (val != '0);
                  done = 1'b1;
               end
               OP_WAIT: begin
                  if (!wait_on) begin
                     wait_on   = 1'b1;
                     wait_base = r.now_ms;
                     wait_left = {1'b0, val};
                  end else begin
                     // elapsed time taken modulo 2^32, done once the remainder goes negative
                     wait_left = {1'b0, val} - (r.now_ms - wait_base);
                     if (wait_left[31]) begin
                        done      = 1'b1;
                        wait_on   = 1'b0;
                        wait_left = '0;
                     end
                  end
               end
               OP_PAUSE: paused = (val == '0);
               default: ;
            endcase
            // advance, wrapping at the table depth or at an end marker
            if (done) begin
               nxt = {1'b0, step_ptr} + 4'd1;
               if (int'(nxt) >= PROGRAM_DEPTH || prog_op[nxt[2:0]] == OP_END)
                  step_ptr = '0;
               else
                  step_ptr = nxt[2:0];
            end
         end
         e.inflow_on     = inflow_q;
         e.outflow_on    = outflow_q;
         e.current_step  = step_ptr;
         e.countdown_ms  = (prog_op[step_ptr] == OP_WAIT) ? wait_left : '0;
         e.step_finished = done;
         e.is_paused     = paused;
      end
   endtask

   // Watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         reset_sequencer();
         predicted_states.delete();
         error_count     <= 0;
         results_pending <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LOOP_ENABLED:     loop_en  = csr_wdata[0];
               CSR_DENSITY_SETPOINT: setpoint = csr_wdata;
               default: ;
            endcase
         end

         // result transfer: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got_state = rsp_data;
            if (predicted_states.size() == 0) begin
               note_failure("result transfer with no prediction pending");
            end else begin
               want_state = predicted_states.pop_front();
               if (got_state.inflow_on !== want_state.inflow_on)
                  note_failure($sformatf("inflow_on got %0b expected %0b",
                     got_state.inflow_on, want_state.inflow_on));
               if (got_state.outflow_on !== want_state.outflow_on)
                  note_failure($sformatf("outflow_on got %0b expected %0b",
                     got_state.outflow_on, want_state.outflow_on));
               if (got_state.current_step !== want_state.current_step)
                  note_failure($sformatf("current_step got %0d expected %0d",
                     got_state.current_step, want_state.current_step));
               if (got_state.countdown_ms !== want_state.countdown_ms)
                  note_failure($sformatf("countdown_ms got %0d expected %0d",
                     got_state.countdown_ms, want_state.countdown_ms));
               if (got_state.step_finished !== want_state.step_finished)
                  note_failure($sformatf("step_finished got %0b expected %0b",
                     got_state.step_finished, want_state.step_finished));
               if (got_state.is_paused !== want_state.is_paused)
                  note_failure($sformatf("is_paused got %0b expected %0b",
                     got_state.is_paused, want_state.is_paused));
            end
         end

         // item transfer: predict its result
         if (req_valid && !req_stall) begin
            advance_sequencer(req_data, next_state);
            predicted_states.push_back(next_state);
         end

         results_pending <= predicted_states.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the dilution program sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import dps_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;

   // opcode codes with no defined meaning
   localparam logic [2:0] OP_UNDEF_LO = 3'd6;
   localparam logic [2:0] OP_UNDEF_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int error_count;
   int results_pending;

   // stimulus controls
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_requests;
   int          items_sent;
   logic [31:0] ms_clock;
   logic [15:0] setpoint_now;

   dilution_protocol_sequencer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   dps_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .results_pending  (results_pending)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, plus long hold-offs when asked for
   initial begin : receiver
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type make_tick(input logic [31:0] now, input logic [15:0] sample);
      req_type r;
      r.func           = FUNC_TICK;
      r.now_ms         = now;
      r.density_sample = sample;
      r.load_index     = 3'($urandom);
      r.load_opcode    = 3'($urandom);
      r.load_value     = 31'($urandom);
      return r;
   endfunction

   function automatic req_type make_load(input logic [2:0] idx, input logic [2:0] op,
                                         input logic [30:0] val);
      req_type r;
      r.func           = FUNC_LOAD;
      r.now_ms         = $urandom;
      r.density_sample = 16'($urandom);
      r.load_index     = idx;
      r.load_opcode    = op;
      r.load_value     = val;
      return r;
   endfunction

   // density either side of the current setpoint
   function automatic logic [15:0] pick_sample();
      if ($urandom_range(1) == 0)
         return 16'($urandom_range(setpoint_now, 0));
      else
         return 16'($urandom_range(65535, setpoint_now));
   endfunction

   // Offer one item and hold it until its transfer; entered and left at a falling edge
   task send_item(input req_type r);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= r;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         items_sent++;
         @(negedge clock);
      end
   endtask

   task send_tick(input logic [31:0] now, input logic [15:0] sample);
      begin
         ms_clock = now;
         send_item(make_tick(now, sample));
      end
   endtask

   task send_load(input logic [2:0] idx, input logic [2:0] op, input logic [30:0] val);
      send_item(make_load(idx, op, val));
   endtask

   // Drop valid and wait until every predicted result has been transferred
   task wait_idle();
      begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (results_pending != 0) @(negedge clock);
         repeat (3) @(negedge clock);
      end
   endtask

   task write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_wdata        <= data;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         @(negedge clock);
      end
   endtask

   // New register settings, written only once the block has drained
   task configure(input logic en, input logic [15:0] sp);
      logic [CSR_DATA_W-1:0] en_word;
      begin
         wait_idle();
         en_word    = CSR_DATA_W'($urandom);
         en_word[0] = en;
         write_csr(CSR_LOOP_ENABLED, en_word);
         write_csr(CSR_DENSITY_SETPOINT, sp);
         setpoint_now = sp;
      end
   endtask

   // A whole program written over the table, then a run of ticks through it
   task program_run();
      int          len;
      int          i;
      int          nticks;
      opcode_type  op;
      logic [30:0] val;
      begin
         len = $urandom_range(8, 2);
         for (i = 0; i < 8; i++) begin
            if (i == len) begin
               send_load(3'(i), OP_END, 31'($urandom));
            end else begin
               case ($urandom_range(3))
                  0: begin
                     op  = OP_MONITOR;
                     val = ($urandom_range(3) == 0) ? '0 : 31'($urandom);
                  end
                  1: begin
                     op  = OP_OUTFLOW;
                     val = ($urandom_range(1) == 0) ? 31'($urandom_range(1)) : 31'($urandom);
                  end
                  2: begin
                     op  = OP_INFLOW;
                     val = ($urandom_range(1) == 0) ? 31'($urandom_range(1)) : 31'($urandom);
                  end
                  default: begin
                     op  = OP_WAIT;
                     val = 31'($urandom_range(12));
                  end
               endcase
               send_load(3'(i), op, val);
            end
         end
         nticks = $urandom_range(40, 10);
         for (i = 0; i < nticks; i++)
            send_tick(ms_clock + $urandom_range(5), pick_sample());
      end
   endtask

   // Loose items: any opcode, time jumps, loads landing mid-wait
   task noise_burst();
      int          n;
      int          i;
      logic [2:0]  op;
      logic [30:0] val;
      begin
         n = $urandom_range(10, 3);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) begin
               op  = 3'($urandom);
               val = 31'($urandom);
               // a pause with value zero would freeze the rest of the run
               if (op == OP_PAUSE && val == '0)
                  val = 31'd1;
               send_load(3'($urandom), op, val);
            end else if ($urandom_range(3) == 0) begin
               send_tick($urandom, 16'($urandom));
            end else begin
               send_tick(ms_clock + $urandom_range(8), 16'($urandom));
            end
         end
      end
   endtask

   task random_phase(input int n);
      int target;
      begin
         target = items_sent + n;
         while (items_sent < target) begin
            if ($urandom_range(99) < 80)
               program_run();
            else
               noise_burst();
         end
      end
   endtask

   task set_idling(input int send_pct, input int recv_pct);
      begin
         send_idle_pct  = send_pct;
         recv_stall_pct = recv_pct;
      end
   endtask

   // Main stimulus
   initial begin : stimulus
      int i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_requests    = 0;
      items_sent       = 0;
      ms_clock         = '0;
      setpoint_now     = SETPOINT_RESET;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // loop still disabled after reset: tick does nothing
      send_tick(32'd0, 16'h0000);
      send_load(3'd0, OP_MONITOR, 31'h7FFF_FFFF);
      send_load(3'd1, OP_OUTFLOW, 31'd1);
      send_load(3'd2, OP_INFLOW, 31'h7FFF_FFFF);
      send_load(3'd3, OP_WAIT, 31'd3);
      send_load(3'd4, OP_OUTFLOW, 31'd0);
      send_load(3'd5, OP_UNDEF_LO, 31'd0);
      send_load(3'd7, OP_INFLOW, 31'd0);
      configure(1'b1, SETPOINT_RESET);
      // monitor: density at the top holds, density zero completes
      send_tick(32'd100, 16'hFFFF);
      send_tick(32'd101, 16'h0000);
      send_tick(32'd102, 16'd1234);
      send_tick(32'hFFFF_FFFD, 16'd500);
      // wait across the wrap of the millisecond time, with a load in the middle
      send_tick(32'hFFFF_FFFE, 16'd500);
      send_load(3'd6, OP_PAUSE, 31'd5);
      send_tick(32'hFFFF_FFFF, 16'd500);
      send_tick(32'd1, 16'd500);
      send_tick(32'd2, 16'd500);
      send_tick(32'd3, 16'd500);
      // undefined opcode holds, then an end marker at the pointer holds
      send_tick(32'd4, 16'd500);
      send_load(3'd5, OP_END, 31'h7FFF_FFFF);
      send_tick(32'd5, 16'd500);
      send_load(3'd5, OP_MONITOR, 31'd0);
      send_tick(32'd6, 16'hFFFF);
      // pause with a nonzero value clears the flag and holds
      send_tick(32'd7, 16'd500);
      send_load(3'd6, OP_UNDEF_HI, 31'd0);

      // no idling, one long receiver hold-off while items keep coming
      configure(1'b1, 16'd1000);
      set_idling(0, 0);
      hold_requests++;
      random_phase(300);

      configure(1'b1, 16'd0);
      set_idling(56, 0);
      random_phase(300);

      configure(1'b1, 16'hFFFF);
      set_idling(0, 56);
      random_phase(300);

      configure(1'b0, 16'd300);
      set_idling(27, 27);
      random_phase(150);

      configure(1'b1, 16'($urandom));
      set_idling(27, 27);
      random_phase(400);

      configure(1'b1, SETPOINT_RESET);
      set_idling(0, 0);
      random_phase(400);

      // pause with value zero is final: ticks stop, loads still land
      set_idling(27, 27);
      for (i = 0; i < 8; i++)
         send_load(3'(i), OP_PAUSE, 31'd0);
      for (i = 0; i < 4; i++)
         send_tick(ms_clock + 32'd1, pick_sample());
      send_load(3'd0, OP_MONITOR, 31'd0);
      send_load(3'd1, OP_WAIT, 31'd2);
      for (i = 0; i < 4; i++)
         send_tick(ms_clock + 32'd3, pick_sample());

      wait_idle();
      repeat (5) @(negedge clock);
      if (error_count == 0 && results_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
